// ----- src/lla_pkg.sv -----
`timescale 1ns / 1ps

package lla_pkg;

  // Per-cell controls driven by the sequencer in the top level.
  typedef struct packed {
    logic shift;   // take the neighbor's counter (ring rotates by one)
    logic inc;     // charge this cell's counter, saturating
  } cell_ctrl_t;

endpackage

// ----- src/least_loaded_bin_assigner.sv -----
`timescale 1ns / 1ps

// Least-loaded bin assigner. One saturating load counter per bin sits in a ring of
// MAX_BOXES cells. A request naming a bin in use charges that bin directly, with no
// scan; a named bin beyond box_count, or a box_count of zero, gives an invalid
// result. A request for bin 0 rotates the ring once, so every counter passes the head
// cell where the running minimum (lowest bin on ties) is kept, then charges the
// winner. One request is in work at a time; a finished result waits in the output
// register while the next request is already accepted. Writes to box_count are
// taken at any time but only change behavior when made between requests.
module least_loaded_bin_assigner #(
  parameter int MAX_BOXES  = 128,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_target_box,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_chosen_box,
  output logic       out_invalid,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_box_count
);
  import lla_pkg::*;

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_BOXES - 1);
  localparam logic [CW-1:0]    MAX_CW    = CW'(MAX_BOXES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_CHARGE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [7:0]            box_count_r;
  logic [CW-1:0]         n_r, n_nxt;
  logic [IDX_W-1:0]      step_r, step_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] best_r, best_nxt;
  logic                  bad_r, bad_nxt;
  logic                  out_valid_r;
  logic [7:0]            out_chosen_box_r;
  logic                  out_invalid_r;

  logic                  in_fire;
  logic                  charge_fire;
  logic [CW-1:0]         n_eff;
  logic [CW-1:0]         tgt_ext;
  logic [CW-1:0]         tgt_m1;
  logic [CW-1:0]         chosen_ext;
  logic [COUNT_BITS-1:0] head;

  cell_ctrl_t            cell_ctrl [MAX_BOXES];
  logic [COUNT_BITS-1:0] loads     [MAX_BOXES];

  // Cell i takes from cell i+1, so after k shifts the head cell holds bin k+1.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_ring
    assign cell_ctrl[i].shift = (state_r == ST_SCAN);
    assign cell_ctrl[i].inc   = charge_fire && !bad_r && (idx_r == IDX_W'(i));

    lla_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl[i]),
      .load_in  (loads[(i + 1) % MAX_BOXES]),
      .load_out (loads[i])
    );
  end

  assign head        = loads[0];
  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign charge_fire = (state_r == ST_CHARGE) && (!out_valid_r || out_ready);
  assign cfg_ready   = 1'b1;

  assign n_eff      = (CW'(box_count_r) > MAX_CW) ? MAX_CW : CW'(box_count_r);
  assign tgt_ext    = CW'(in_target_box);
  assign tgt_m1     = tgt_ext - CW'(1);
  assign chosen_ext = CW'(idx_r) + CW'(1);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    bad_nxt   = bad_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          n_nxt    = n_eff;
          step_nxt = '0;
          idx_nxt  = '0;
          bad_nxt  = 1'b0;
          if (n_eff == '0) begin
            bad_nxt   = 1'b1;
            state_nxt = ST_CHARGE;
          end else if (in_target_box != 8'd0) begin
            if (tgt_ext > n_eff) begin
              bad_nxt = 1'b1;
            end else begin
              idx_nxt = tgt_m1[IDX_W-1:0];
            end
            state_nxt = ST_CHARGE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // The ring always turns a full lap so every bin is back home for the charge.
        if (step_r == '0) begin
          best_nxt = head;
          idx_nxt  = '0;
        end else if ((CW'(step_r) < n_r) && (head < best_r)) begin
          best_nxt = head;
          idx_nxt  = step_r;
        end
        if (step_r == LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = ST_CHARGE;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      ST_CHARGE: begin
        if (charge_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      box_count_r <= 8'd128;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        box_count_r <= cfg_box_count;
      end
      if (charge_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
    bad_r  <= bad_nxt;
    if (charge_fire) begin
      out_chosen_box_r <= bad_r ? 8'd0 : chosen_ext[7:0];
      out_invalid_r    <= bad_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_chosen_box = out_chosen_box_r;
  assign out_invalid    = out_invalid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_charge_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (charge_fire && !bad_r) |-> (CW'(idx_r) < n_r))
    else $error("charging a bin outside the bins in use");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_chosen_box == 8'd0))
    else $error("invalid result carries a bin number");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_invalid) |-> (out_chosen_box != 8'd0))
    else $error("served result carries bin zero");

endmodule

// ----- src/lla_cell.sv -----
`timescale 1ns / 1ps

module lla_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lla_pkg::cell_ctrl_t    ctrl,
  input  logic [COUNT_BITS-1:0]  load_in,
  output logic [COUNT_BITS-1:0]  load_out
);
  import lla_pkg::*;

  logic [COUNT_BITS-1:0] load_r;
  logic [COUNT_BITS-1:0] load_nxt;

  always_comb begin
    load_nxt = load_r;
    if (ctrl.inc) begin
      if (load_r != {COUNT_BITS{1'b1}}) begin
        load_nxt = load_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end else if (ctrl.shift) begin
      load_nxt = load_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
    end else begin
      load_r <= load_nxt;
    end
  end

  assign load_out = load_r;

endmodule
